@@ design/rhc_pkg.sv @@
package rhc_pkg;

  // Pipeline depth: input register is stage 0, output register is stage LAT-1.
  localparam int LAT       = 20;
  // Divider: one quotient bit per stage, fed from stage DIV_FIRST-1.
  localparam int DIV_STEPS = 16;
  localparam int DIV_FIRST = 3;

  typedef enum logic {
    MODEL_RGB = 1'b0,
    MODEL_HSV = 1'b1
  } model_e;

  localparam logic REG_TARGET = 1'b0;

  localparam logic [15:0] RGB_FULL = 16'd65280;
  localparam logic [15:0] PCT_FULL = 16'd25600;
  localparam logic [15:0] SECTOR_W = 16'd7680;

  // 7680 * 25600: common denominator of the fractional sector terms.
  localparam logic [27:0] HSV_DEN    = 28'd196608000;
  // Reciprocals for exact floor division by a constant.
  localparam logic [27:0] RECIP_1875 = 28'd146601551;  // 2^38 / 1875
  localparam logic [21:0] RECIP_51   = 22'd2631721;    // 2^27 / 51
  localparam logic [20:0] RECIP_5    = 21'd1677722;    // 2^23 / 5

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] third;
    logic [15:0] second;
    logic [15:0] first;
  } color_t;

  typedef logic [LAT-1:0] stage_en_t;

endpackage

@@ design/rhc_div.sv @@
module rhc_div import rhc_pkg::*; (
  input  logic                 clk_i,
  input  logic [DIV_STEPS-1:0] en_i,
  input  logic [31:0]          num_i,
  input  logic [15:0]          den_i,
  output logic [15:0]          quo_o
);

  // The caller guarantees num_i < den_i * 2^16, so the upper half is a valid
  // starting remainder and the quotient fits in 16 bits.
  logic [15:0] rem_q [DIV_STEPS];
  logic [15:0] low_q [DIV_STEPS];
  logic [15:0] quo_q [DIV_STEPS];
  logic [15:0] den_q [DIV_STEPS];

  logic [15:0] rem_d [DIV_STEPS];
  logic [15:0] low_d [DIV_STEPS];
  logic [15:0] quo_d [DIV_STEPS];
  logic [15:0] den_d [DIV_STEPS];

  always_comb begin
    logic [15:0] rem_in, low_in, quo_in, den_in;
    logic [16:0] trial;
    logic        ge;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) begin
        rem_in = num_i[31:16];
        low_in = num_i[15:0];
        quo_in = '0;
        den_in = den_i;
      end else begin
        rem_in = rem_q[j-1];
        low_in = low_q[j-1];
        quo_in = quo_q[j-1];
        den_in = den_q[j-1];
      end
      trial    = {rem_in, low_in[15]};
      ge       = (trial >= {1'b0, den_in});
      rem_d[j] = ge ? 16'(trial - {1'b0, den_in}) : trial[15:0];
      low_d[j] = {low_in[14:0], 1'b0};
      quo_d[j] = {quo_in[14:0], ge};
      den_d[j] = den_in;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d[j];
        low_q[j] <= low_d[j];
        quo_q[j] <= quo_d[j];
        den_q[j] <= den_d[j];
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

@@ design/rhc_rgb2hsv.sv @@
module rhc_rgb2hsv import rhc_pkg::*; (
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  logic [15:0] r_i,
  input  logic [15:0] g_i,
  input  logic [15:0] b_i,
  input  logic [15:0] a_i,
  output logic [15:0] hue_o,
  output logic [15:0] sat_o,
  output logic [15:0] val_o,
  output logic [15:0] alpha_o
);

  localparam int LAST = LAT - 2;

  // Stage 1: clamp channels, find max and min.
  logic [15:0] r1_q, g1_q, b1_q, mx1_q, mn1_q;
  logic [20:0] a20_1_q;
  logic [15:0] rc, gc, bc, mx, mn;

  always_comb begin
    rc = (r_i > RGB_FULL) ? RGB_FULL : r_i;
    gc = (g_i > RGB_FULL) ? RGB_FULL : g_i;
    bc = (b_i > RGB_FULL) ? RGB_FULL : b_i;
    mx = rc;
    mn = rc;
    if (gc > mx) mx = gc;
    if (bc > mx) mx = bc;
    if (gc < mn) mn = gc;
    if (bc < mn) mn = bc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      r1_q    <= rc;
      g1_q    <= gc;
      b1_q    <= bc;
      mx1_q   <= mx;
      mn1_q   <= mn;
      a20_1_q <= 21'(a_i) * 21'd20;
    end
  end

  // Stage 2: delta, hue and saturation numerators.
  logic [31:0] hnum2_q, snum2_q;
  logic [15:0] d2_q, mx2_q;
  logic [20:0] v20_2_q;
  logic [42:0] aprod2_q;
  logic        dz2_q, mz2_q;
  logic [15:0] d;
  logic [33:0] hn;

  always_comb begin
    d = mx1_q - mn1_q;
    if (mx1_q == r1_q) begin
      hn = 34'(g1_q) * 34'd7680 - 34'(b1_q) * 34'd7680;
      if (g1_q < b1_q) hn = hn + 34'(d) * 34'd46080;
    end else if (mx1_q == g1_q) begin
      hn = 34'(d) * 34'd15360 + 34'(b1_q) * 34'd7680 - 34'(r1_q) * 34'd7680;
    end else begin
      hn = 34'(d) * 34'd30720 + 34'(r1_q) * 34'd7680 - 34'(g1_q) * 34'd7680;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      hnum2_q  <= hn[31:0];
      snum2_q  <= 32'(d) * 32'd25600;
      d2_q     <= d;
      mx2_q    <= mx1_q;
      v20_2_q  <= 21'(mx1_q) * 21'd20;
      aprod2_q <= 43'(a20_1_q) * 43'(RECIP_51);
      dz2_q    <= (d == '0);
      mz2_q    <= (mx1_q == '0);
    end
  end

  // Hue and saturation dividers, stages 3 to LAT-2.
  logic [15:0] hue_quo, sat_quo;

  rhc_div u_hue_div (
    .clk_i (clk_i),
    .en_i  (en_i[DIV_FIRST +: DIV_STEPS]),
    .num_i (hnum2_q),
    .den_i (d2_q),
    .quo_o (hue_quo)
  );

  rhc_div u_sat_div (
    .clk_i (clk_i),
    .en_i  (en_i[DIV_FIRST +: DIV_STEPS]),
    .num_i (snum2_q),
    .den_i (mx2_q),
    .quo_o (sat_quo)
  );

  // Value and alpha run beside the dividers.
  logic [42:0] vprod3_q;
  logic [15:0] alpha_q [LAST:3];
  logic [15:0] val_q   [LAST:4];
  logic        dz_q    [LAST:3];
  logic        mz_q    [LAST:3];
  logic [15:0] a_scl;

  assign a_scl = (aprod2_q[42:27] > PCT_FULL) ? PCT_FULL : aprod2_q[42:27];

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      vprod3_q   <= 43'(v20_2_q) * 43'(RECIP_51);
      alpha_q[3] <= a_scl;
      dz_q[3]    <= dz2_q;
      mz_q[3]    <= mz2_q;
    end
    if (en_i[4]) val_q[4] <= vprod3_q[42:27];
    for (int k = 4; k <= LAST; k++) begin
      if (en_i[k]) begin
        alpha_q[k] <= alpha_q[k-1];
        dz_q[k]    <= dz_q[k-1];
        mz_q[k]    <= mz_q[k-1];
      end
    end
    for (int k = 5; k <= LAST; k++) begin
      if (en_i[k]) val_q[k] <= val_q[k-1];
    end
  end

  assign hue_o   = dz_q[LAST] ? '0 : hue_quo;
  assign sat_o   = mz_q[LAST] ? '0 : sat_quo;
  assign val_o   = val_q[LAST];
  assign alpha_o = alpha_q[LAST];

endmodule

@@ design/rhc_hsv2rgb.sv @@
module rhc_hsv2rgb import rhc_pkg::*; (
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  logic [15:0] h_i,
  input  logic [15:0] s_i,
  input  logic [15:0] v_i,
  input  logic [15:0] a_i,
  output logic [15:0] r_o,
  output logic [15:0] g_o,
  output logic [15:0] b_o,
  output logic [15:0] alpha_o
);

  localparam int LAST  = LAT - 2;
  localparam int LANES = 4;  // value, p, q, t

  // Stage 1: sector and fraction, clamp saturation and value.
  logic [3:0]  idx;
  logic [15:0] f_full;
  logic [2:0]  sec;
  logic [2:0]  sec_q [1:5];
  logic [12:0] f1_q;
  logic [14:0] s1_q, v1_q;
  logic [21:0] a51_1_q;
  logic [15:0] sc, vc;

  always_comb begin
    idx = '0;
    for (int k = 1; k <= 8; k++) begin
      if (32'(h_i) >= 32'(k) * 32'(SECTOR_W)) idx = idx + 4'd1;
    end
    f_full = 16'(32'(h_i) - 32'(idx) * 32'(SECTOR_W));
    sec    = (idx >= 4'd6) ? 3'(idx - 4'd6) : idx[2:0];
    sc     = (s_i > PCT_FULL) ? PCT_FULL : s_i;
    vc     = (v_i > PCT_FULL) ? PCT_FULL : v_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sec_q[1] <= sec;
      f1_q     <= f_full[12:0];
      s1_q     <= sc[14:0];
      v1_q     <= vc[14:0];
      a51_1_q  <= 22'(a_i) * 22'd51;
    end
  end

  // Each lane computes floor(v * (DEN - m*s) * 255 / (DEN * 100)).
  logic [12:0] m [LANES];
  logic [27:0] w2_q [LANES];
  logic [42:0] x3_q [LANES];
  logic [48:0] y4_q [LANES];
  logic [55:0] z5_q [LANES];
  logic [14:0] v2_q;
  logic [40:0] ap2_q;
  logic [15:0] lane [LANES];

  always_comb begin
    m[0] = '0;
    m[1] = SECTOR_W[12:0];
    m[2] = f1_q;
    m[3] = 13'(SECTOR_W[12:0] - f1_q);
    for (int l = 0; l < LANES; l++) begin
      lane[l] = z5_q[l][53:38];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int l = 0; l < LANES; l++) begin
        w2_q[l] <= HSV_DEN - 28'(m[l]) * 28'(s1_q);
      end
      v2_q     <= v1_q;
      sec_q[2] <= sec_q[1];
      ap2_q    <= 41'(a51_1_q[21:2]) * 41'(RECIP_5);
    end
    if (en_i[3]) begin
      for (int l = 0; l < LANES; l++) x3_q[l] <= 43'(v2_q) * 43'(w2_q[l]);
      sec_q[3] <= sec_q[2];
    end
    if (en_i[4]) begin
      for (int l = 0; l < LANES; l++) y4_q[l] <= 49'(x3_q[l]) * 49'd51;
      sec_q[4] <= sec_q[3];
    end
    if (en_i[5]) begin
      for (int l = 0; l < LANES; l++) begin
        z5_q[l] <= 56'(y4_q[l][48:21]) * 56'(RECIP_1875);
      end
      sec_q[5] <= sec_q[4];
    end
  end

  // Stage 6: route value, p, q and t to the channels by sector.
  logic [15:0] r_q [LAST:6];
  logic [15:0] g_q [LAST:6];
  logic [15:0] b_q [LAST:6];
  logic [15:0] alpha_q [LAST:3];
  logic [15:0] rs, gs, bs;
  logic [15:0] a_scl;

  always_comb begin
    case (sec_q[5])
      3'd0:    begin rs = lane[0]; gs = lane[3]; bs = lane[1]; end
      3'd1:    begin rs = lane[2]; gs = lane[0]; bs = lane[1]; end
      3'd2:    begin rs = lane[1]; gs = lane[0]; bs = lane[3]; end
      3'd3:    begin rs = lane[1]; gs = lane[2]; bs = lane[0]; end
      3'd4:    begin rs = lane[3]; gs = lane[1]; bs = lane[0]; end
      default: begin rs = lane[0]; gs = lane[1]; bs = lane[2]; end
    endcase
    a_scl = (ap2_q[40:23] > 18'(RGB_FULL)) ? RGB_FULL : ap2_q[38:23];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) alpha_q[3] <= a_scl;
    for (int k = 4; k <= LAST; k++) begin
      if (en_i[k]) alpha_q[k] <= alpha_q[k-1];
    end
    if (en_i[6]) begin
      r_q[6] <= rs;
      g_q[6] <= gs;
      b_q[6] <= bs;
    end
    for (int k = 7; k <= LAST; k++) begin
      if (en_i[k]) begin
        r_q[k] <= r_q[k-1];
        g_q[k] <= g_q[k-1];
        b_q[k] <= b_q[k-1];
      end
    end
  end

  assign r_o     = r_q[LAST];
  assign g_o     = g_q[LAST];
  assign b_o     = b_q[LAST];
  assign alpha_o = alpha_q[LAST];

endmodule

@@ design/rgb_hsv_converter_core.sv @@
// Converts one fixed-point color word per clock between the RGB and HSV models.
// Each input word carries its model in tuser; the target_model register (APB,
// byte address 0, bit 0: 0 RGB, 1 HSV) selects the model of every output word,
// and a word already in that model passes through untouched. RGB channels and
// RGB alpha are Q8.8 (0..255), saturation, value and HSV alpha are Q7.8
// (0..100) and hue is Q9.7 (0..360); all converted results are truncated.
// The pipeline is 20 register stages deep. One word can be accepted every
// cycle while the output is not stalled; the depth is set by the two 16-step
// restoring dividers for hue and saturation. Every stage holds its word while
// the next one is not loading, so a stall at the output backs up without
// losing words and empty stages still fill. Write target_model only while the
// pipeline is empty.
module rgb_hsv_converter_core import rhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // in_first, in_second, in_third, in_alpha
  input  logic        s_axis_tuser_i,   // in_model
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // out_first, out_second, out_third, out_alpha
  output logic        m_axis_tuser_o,   // out_model
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration register.
  logic tgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= MODEL_RGB;
    end else if (psel && penable && pwrite && (paddr == REG_TARGET)) begin
      tgt_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_TARGET) ? {31'b0, tgt_q} : '0;

  // Per-stage valid bits and load enables. A stage loads when it is empty or
  // when the stage after it is loading too.
  logic [LAT-1:0] vld_q;
  stage_en_t      en;

  always_comb begin
    en[LAT-1] = !vld_q[LAT-1] || m_axis_tready_i;
    for (int k = LAT - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < LAT; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // Stage 0 captures the incoming word, its bypass decision and the target.
  color_t col0_q;
  logic   pass_q [LAT-2:0];
  logic   tgt_s_q [LAT-2:0];
  color_t col_q  [LAT-2:1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      col0_q     <= color_t'(s_axis_tdata_i);
      pass_q[0]  <= (s_axis_tuser_i == tgt_q);
      tgt_s_q[0] <= tgt_q;
    end
    if (en[1]) col_q[1] <= col0_q;
    for (int k = 2; k <= LAT - 2; k++) begin
      if (en[k]) col_q[k] <= col_q[k-1];
    end
    for (int k = 1; k <= LAT - 2; k++) begin
      if (en[k]) begin
        pass_q[k]  <= pass_q[k-1];
        tgt_s_q[k] <= tgt_s_q[k-1];
      end
    end
  end

  // Both conversions run on every word; the output stage picks one or the bypassed word.
  color_t hsv_res, rgb_res;

  rhc_rgb2hsv u_rgb2hsv (
    .clk_i   (clk_i),
    .en_i    (en),
    .r_i     (col0_q.first),
    .g_i     (col0_q.second),
    .b_i     (col0_q.third),
    .a_i     (col0_q.alpha),
    .hue_o   (hsv_res.first),
    .sat_o   (hsv_res.second),
    .val_o   (hsv_res.third),
    .alpha_o (hsv_res.alpha)
  );

  rhc_hsv2rgb u_hsv2rgb (
    .clk_i   (clk_i),
    .en_i    (en),
    .h_i     (col0_q.first),
    .s_i     (col0_q.second),
    .v_i     (col0_q.third),
    .a_i     (col0_q.alpha),
    .r_o     (rgb_res.first),
    .g_o     (rgb_res.second),
    .b_o     (rgb_res.third),
    .alpha_o (rgb_res.alpha)
  );

  // Output register.
  color_t out_col_q, out_col_d;
  logic   out_model_q;

  always_comb begin
    if (pass_q[LAT-2]) begin
      out_col_d = col_q[LAT-2];
    end else if (tgt_s_q[LAT-2] == MODEL_HSV) begin
      out_col_d = hsv_res;
    end else begin
      out_col_d = rgb_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LAT-1]) begin
      out_col_q   <= out_col_d;
      out_model_q <= tgt_s_q[LAT-2];
    end
  end

  assign m_axis_tvalid_o = vld_q[LAT-1];
  assign m_axis_tdata_o  = out_col_q;
  assign m_axis_tuser_o  = out_model_q;

endmodule
